// ----- sv/szbuf_pkg.sv -----
package szbuf_pkg;

  localparam int LINE_WIDTH  = 1280;
  localparam int ADDR_W      = $clog2(LINE_WIDTH);
  localparam int COL_W       = 12;
  localparam int OWNER_W     = 8;
  localparam int DEPTH_W     = 24;
  localparam int ENTRY_W     = OWNER_W + DEPTH_W;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [COL_W:0]         LINE_END  = (COL_W + 1)'(LINE_WIDTH);
  localparam logic [COL_W-1:0]       LAST_COL  = COL_W'(LINE_WIDTH - 1);
  localparam logic [ADDR_W-1:0]      LAST_ADDR = ADDR_W'(LINE_WIDTH - 1);
  localparam logic signed [DEPTH_W-1:0] DEPTH_MAX = {1'b0, {(DEPTH_W - 1){1'b1}}};
  localparam logic signed [DEPTH_W-1:0] DEPTH_MIN = {1'b1, {(DEPTH_W - 1){1'b0}}};

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_SPAN  = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef struct packed {
    op_t                        operation;
    logic [COL_W-1:0]           x_left;
    logic [COL_W-1:0]           x_right;
    logic signed [DEPTH_W-1:0]  start_depth;
    logic signed [DEPTH_W-1:0]  depth_step;
    logic [OWNER_W-1:0]         span_owner;
    logic [COL_W-1:0]           read_x;
  } item_t;

  typedef struct packed {
    logic [COL_W-1:0]           pixel_column;
    logic [OWNER_W-1:0]         pixel_owner;
    logic signed [DEPTH_W-1:0]  pixel_depth;
  } pixel_t;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_SPAN  = 2'd1,
    CMD_READ  = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t                  kind;
    logic [ADDR_W-1:0]          x_first;
    logic [ADDR_W-1:0]          x_last;
    logic [COL_W-1:0]           column;
    logic                       in_range;
    logic signed [DEPTH_W-1:0]  start_depth;
    logic signed [DEPTH_W-1:0]  depth_step;
    logic [OWNER_W-1:0]         owner;
  } cmd_t;

  function automatic logic signed [DEPTH_W-1:0] sat_sub(
    input logic signed [DEPTH_W-1:0] a,
    input logic signed [DEPTH_W-1:0] b
  );
    logic signed [DEPTH_W:0] d;
    d = {a[DEPTH_W-1], a} - {b[DEPTH_W-1], b};
    if (d[DEPTH_W] != d[DEPTH_W-1]) begin
      return d[DEPTH_W] ? DEPTH_MIN : DEPTH_MAX;
    end
    return d[DEPTH_W-1:0];
  endfunction

endpackage

// ----- sv/szbuf_ram.sv -----
module szbuf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/szbuf_front.sv -----
module szbuf_front
  import szbuf_pkg::*;
(
  input  logic  item_valid,
  output logic  item_stall,
  input  item_t item,
  input  logic  init_busy,
  input  logic  q_full,
  output logic  q_push,
  output cmd_t  q_cmd
);

  logic             accept;
  logic             keep;
  logic             left_ok;
  logic [COL_W-1:0] xr_clip;

  assign item_stall = init_busy || q_full;
  assign accept     = item_valid && !item_stall;
  assign q_push     = accept && keep;

  always_comb begin
    left_ok = {1'b0, item.x_left} < LINE_END;
    xr_clip = ({1'b0, item.x_right} >= LINE_END) ? LAST_COL : item.x_right;

    q_cmd.kind        = CMD_CLEAR;
    q_cmd.x_first     = item.x_left[ADDR_W-1:0];
    q_cmd.x_last      = xr_clip[ADDR_W-1:0];
    q_cmd.column      = item.read_x;
    q_cmd.in_range    = {1'b0, item.read_x} < LINE_END;
    q_cmd.start_depth = item.start_depth;
    q_cmd.depth_step  = item.depth_step;
    q_cmd.owner       = item.span_owner;
    keep              = 1'b0;

    case (item.operation)
      OP_CLEAR: begin
        keep = 1'b1;
      end
      OP_SPAN: begin
        q_cmd.kind = CMD_SPAN;
        keep       = left_ok && (item.x_left <= xr_clip);
      end
      OP_READ: begin
        q_cmd.kind    = CMD_READ;
        q_cmd.x_first = item.read_x[ADDR_W-1:0];
        keep          = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

endmodule

// ----- sv/szbuf_queue.sv -----
module szbuf_queue
  import szbuf_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic empty,
  output cmd_t head
);

  cmd_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full  = count == (QPTR_W + 1)'(QUEUE_DEPTH);
  assign empty = count == '0;
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

// ----- sv/szbuf_back.sv -----
module szbuf_back
  import szbuf_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   q_empty,
  input  cmd_t   q_head,
  output logic   q_pop,
  output logic   init_busy,
  output logic   pixel_valid,
  input  logic   pixel_stall,
  output pixel_t pixel
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_CLEAR = 5'b00010,
    ST_SPAN  = 5'b00100,
    ST_DRAIN = 5'b01000,
    ST_READ  = 5'b10000
  } state_t;

  state_t                    state;
  logic [ADDR_W-1:0]         x;
  cmd_t                      cur;
  logic signed [DEPTH_W-1:0] z;
  logic                      p_valid;
  logic [ADDR_W-1:0]         p_x;
  logic signed [DEPTH_W-1:0] p_z;

  logic                      out_free;
  logic                      ram_we;
  logic [ADDR_W-1:0]         ram_waddr;
  logic [ENTRY_W-1:0]        ram_wdata;
  logic                      ram_re;
  logic [ADDR_W-1:0]         ram_raddr;
  logic [ENTRY_W-1:0]        ram_rdata;
  logic signed [DEPTH_W-1:0] rd_depth;
  logic [OWNER_W-1:0]        rd_owner;

  assign out_free = !pixel_valid || !pixel_stall;
  assign q_pop    = (state == ST_IDLE) && !q_empty
                    && ((q_head.kind != CMD_READ) || out_free);

  assign rd_depth = ram_rdata[DEPTH_W-1:0];
  assign rd_owner = ram_rdata[ENTRY_W-1:DEPTH_W];

  // read-modify-write: read at x now, compare and write in the following cycle
  assign ram_re    = (state == ST_SPAN) || (q_pop && (q_head.kind == CMD_READ));
  assign ram_raddr = (state == ST_SPAN) ? x : q_head.x_first;
  assign ram_we    = (state == ST_CLEAR) || (p_valid && (p_z > rd_depth));
  assign ram_waddr = (state == ST_CLEAR) ? x : p_x;
  assign ram_wdata = (state == ST_CLEAR) ? '0 : {cur.owner, p_z};

  szbuf_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (LINE_WIDTH)
  ) u_line (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      x           <= '0;
      init_busy   <= 1'b1;
      p_valid     <= 1'b0;
      pixel_valid <= 1'b0;
    end else begin
      p_valid <= state == ST_SPAN;
      if (pixel_valid && !pixel_stall) begin
        pixel_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (q_pop) begin
            case (q_head.kind)
              CMD_CLEAR: begin
                x     <= '0;
                state <= ST_CLEAR;
              end
              CMD_SPAN: begin
                x     <= q_head.x_first;
                state <= ST_SPAN;
              end
              CMD_READ: begin
                state <= ST_READ;
              end
              default: begin
                state <= ST_IDLE;
              end
            endcase
          end
        end
        ST_CLEAR: begin
          x <= x + 1'b1;
          if (x == LAST_ADDR) begin
            init_busy <= 1'b0;
            state     <= ST_IDLE;
          end
        end
        ST_SPAN: begin
          x <= x + 1'b1;
          if (x == cur.x_last) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          state <= ST_IDLE;
        end
        ST_READ: begin
          pixel_valid <= 1'b1;
          state       <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    p_x <= x;
    p_z <= z;
    if (q_pop) begin
      cur <= q_head;
      z   <= q_head.start_depth;
    end else if (state == ST_SPAN) begin
      z <= sat_sub(z, cur.depth_step);
    end
    if (state == ST_READ) begin
      pixel.pixel_column <= cur.column;
      pixel.pixel_owner  <= cur.in_range ? rd_owner : '0;
      pixel.pixel_depth  <= cur.in_range ? rd_depth : '0;
    end
  end

endmodule

// ----- sv/scanline_zbuffer_span_composite_top.sv -----
// Scanline depth buffer: one line of owner IDs and Q16.8 depths in a single
// dual-port RAM. A front stage classifies words (clip span ends, drop empty
// spans and unused codes) into a four-entry queue; the back end executes
// them. Span: one read-modify-write per pixel through the RAM's single
// write port. Read: result held in an output register. After reset the
// back end runs a zeroing pass over all LINE_WIDTH entries with item_stall
// high.
module scanline_zbuffer_span_composite_top
  import szbuf_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   item_valid,
  output logic   item_stall,
  input  item_t  item,
  output logic   pixel_valid,
  input  logic   pixel_stall,
  output pixel_t pixel
);

  logic init_busy;
  logic q_push;
  cmd_t q_cmd;
  logic q_full;
  logic q_pop;
  logic q_empty;
  cmd_t q_head;

  szbuf_front u_front (
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .init_busy  (init_busy),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_cmd      (q_cmd)
  );

  szbuf_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head     (q_head)
  );

  szbuf_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .init_busy   (init_busy),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .pixel       (pixel)
  );

endmodule

// ----- sv/szbuf_chk.sv -----
module szbuf_chk
  import szbuf_pkg::*;
(
  input logic   clk,
  input logic   rst,
  input logic   pixel_valid,
  input logic   pixel_stall,
  input pixel_t pixel
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    pixel_valid && pixel_stall |=> pixel_valid && $stable(pixel))
    else $error("stalled pixel word changed");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !pixel_valid)
    else $error("pixel word valid after reset");

  a_off_line: assert property (@(posedge clk) disable iff (rst)
    pixel_valid && ({1'b0, pixel.pixel_column} >= LINE_END)
    |-> (pixel.pixel_owner == '0) && (pixel.pixel_depth == '0))
    else $error("column past line returned stored data");

  a_depth_nonneg: assert property (@(posedge clk) disable iff (rst)
    pixel_valid |-> !pixel.pixel_depth[DEPTH_W-1])
    else $error("stored depth below cleared level");

  a_bg_owner: assert property (@(posedge clk) disable iff (rst)
    pixel_valid && (pixel.pixel_depth == '0) |-> pixel.pixel_owner == '0)
    else $error("owner written without a nearer depth");

endmodule

bind scanline_zbuffer_span_composite_top szbuf_chk u_chk (.*);
